// File: src/gql_pkg.sv
// Shared types and constants of the glyph quad layout block.
package gql_pkg;

  localparam int TEX_W      = 16;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = TEX_W / DIV_STEPS;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam logic [TEX_W-1:0] TEX_MAX = {TEX_W{1'b1}};

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  w;
    logic [7:0]  h;
  } glyph_t;

  typedef struct packed {
    logic             start;
    logic [TEX_W:0]   texel;
    logic [TEX_W-1:0] size;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TEX_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: src/gql_in_if.sv
// Input item channel of the glyph quad layout block.
interface gql_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  font_sel;
  logic [6:0]  slot;
  logic [7:0]  char_code;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [7:0]  size_w;
  logic [7:0]  size_h;

  modport source (
    output valid, func, font_sel, slot, char_code, pos_x, pos_y, size_w, size_h,
    input  ready
  );
  modport sink (
    input  valid, func, font_sel, slot, char_code, pos_x, pos_y, size_w, size_h,
    output ready
  );
endinterface

// File: src/gql_out_if.sv
// Vertex output channel of the glyph quad layout block.
interface gql_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] vert_x;
  logic [15:0] vert_y;
  logic [15:0] tex_s;
  logic [15:0] tex_t;
  logic [1:0]  corner;
  logic        last;

  modport source (
    output valid, vert_x, vert_y, tex_s, tex_t, corner, last,
    input  ready
  );
  modport sink (
    input  valid, vert_x, vert_y, tex_s, tex_t, corner, last,
    output ready
  );
endinterface

// File: src/glyph_quad_layout_top.sv
// Top level of the glyph quad layout block: item sequencer, pen state and output register.
//
//   channel  modport  payload                                            transfer
//   items    sink     func font_sel slot char_code pos_x pos_y size_w h  valid && ready
//   verts    source   vert_x vert_y tex_s tex_t corner last              valid && ready
//
// Glyph writes, metric writes, begin and newline items finish in the idle state; tab and
// space items also pass the read state. A drawn glyph takes one glyph memory read, then four
// divisions in the shared divider, then four corner transfers through the output register.
// Reset clears the pen, origin and font metrics; the glyph memory is not cleared.
// A stalled output holds the sequencer in its emit state; items is ready only when idle.
module glyph_quad_layout_top import gql_pkg::*; #(
  parameter int NUM_FONTS   = 4,
  parameter int GLYPH_COUNT = 96
) (
  input logic clk,
  input logic rst,
  gql_in_if.sink    items,
  gql_out_if.source verts
);

  localparam int FIDX_W = (NUM_FONTS > 1) ? $clog2(NUM_FONTS) : 1;
  localparam int DEPTH  = NUM_FONTS * GLYPH_COUNT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] FN_GLYPH = 2'd0;
  localparam logic [1:0] FN_FONT  = 2'd1;
  localparam logic [1:0] FN_BEGIN = 2'd2;
  localparam logic [1:0] FN_CHAR  = 2'd3;

  localparam logic [7:0] CH_FIRST   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;

  logic [7:0]  line_height    [NUM_FONTS];
  logic [15:0] texture_width  [NUM_FONTS];
  logic [15:0] texture_height [NUM_FONTS];
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [15:0] origin_x;

  logic              accept;
  logic [FIDX_W-1:0] fi;
  logic              font_ok;
  logic              slot_ok;
  logic [7:0]        code_g;
  logic              is_nl;
  logic              is_tab;
  logic              is_sp;
  logic              glyph_ok;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  glyph_t            wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        rd_slot;
  glyph_t            rd_data;

  logic [FIDX_W-1:0] f_q;
  logic              adv_q;
  logic              tab_q;
  glyph_t            g_q;
  logic [15:0]       x0;
  logic [15:0]       x1;
  logic [15:0]       y0;
  logic [15:0]       y1;
  logic [TEX_W-1:0]  tex [4];
  logic [1:0]        op;
  logic              div_wait;
  logic [1:0]        k;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        out_valid;
  logic        emit_load;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [15:0] out_s;
  logic [15:0] out_t;
  logic [1:0]  out_corner;
  logic        out_last;

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;

  assign fi       = FIDX_W'(items.font_sel);
  assign font_ok  = int'(items.font_sel) < NUM_FONTS;
  assign slot_ok  = int'(items.slot) < GLYPH_COUNT;
  assign code_g   = items.char_code - CH_FIRST;
  assign is_nl    = (items.char_code == CH_NEWLINE);
  assign is_tab   = (items.char_code == CH_TAB);
  assign is_sp    = (items.char_code == CH_SPACE);
  assign glyph_ok = (items.char_code >= CH_FIRST) && (int'(code_g) < GLYPH_COUNT);

  assign wr_en   = accept && font_ok && (items.func == FN_GLYPH) && slot_ok;
  assign wr_addr = AW'(fi) * AW'(GLYPH_COUNT) + AW'(items.slot);
  assign wr_data = '{x: items.pos_x, y: items.pos_y, w: items.size_w, h: items.size_h};

  assign rd_slot = (is_tab || is_sp) ? 8'd0 : code_g;
  assign rd_addr = AW'(fi) * AW'(GLYPH_COUNT) + AW'(rd_slot);
  assign rd_en   = accept && font_ok && (items.func == FN_CHAR) && !is_nl &&
                   (is_tab || is_sp || glyph_ok);

  gql_glyph_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    div_req.start = (state == S_DIV) && !div_wait;
    div_req.size  = op[1] ? texture_height[f_q] : texture_width[f_q];
    case (op)
      2'd0:    div_req.texel = {1'b0, g_q.x};
      2'd1:    div_req.texel = {1'b0, g_q.x} + (TEX_W + 1)'(g_q.w);
      2'd2:    div_req.texel = {1'b0, g_q.y};
      default: div_req.texel = {1'b0, g_q.y} + (TEX_W + 1)'(g_q.h);
    endcase
  end

  gql_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign emit_load = (state == S_EMIT) && (!out_valid || verts.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pen_x    <= '0;
      pen_y    <= '0;
      origin_x <= '0;
      op       <= '0;
      div_wait <= 1'b0;
      k        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_FONTS; i++) begin
        line_height[i]    <= '0;
        texture_width[i]  <= '0;
        texture_height[i] <= '0;
      end
    end else begin
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (verts.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && font_ok) begin
            case (items.func)
              FN_FONT: begin
                line_height[fi]    <= items.size_h;
                texture_width[fi]  <= items.pos_x;
                texture_height[fi] <= items.pos_y;
              end
              FN_BEGIN: begin
                origin_x <= items.pos_x;
                pen_x    <= items.pos_x;
                pen_y    <= items.pos_y;
              end
              FN_CHAR: begin
                if (is_nl) begin
                  pen_x <= origin_x;
                  pen_y <= pen_y + 16'(line_height[fi]);
                end else if (rd_en) begin
                  state <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          if (adv_q) begin
            pen_x <= pen_x + (tab_q ? {6'b0, rd_data.w, 2'b00} : {8'b0, rd_data.w});
            state <= S_IDLE;
          end else begin
            pen_x    <= pen_x + 16'(rd_data.w);
            op       <= '0;
            div_wait <= 1'b0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_req.start) begin
            div_wait <= 1'b1;
          end else if (div_rsp.done) begin
            div_wait <= 1'b0;
            op       <= op + 1'b1;
            if (op == 2'd3) begin
              k     <= CORNER_TL;
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            k <= k + 1'b1;
            if (k == CORNER_BL) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_q   <= fi;
      adv_q <= is_tab || is_sp;
      tab_q <= is_tab;
    end
    if (state == S_READ) begin
      g_q <= rd_data;
      x0  <= pen_x;
      x1  <= pen_x + 16'(rd_data.w);
      y0  <= pen_y;
      y1  <= pen_y + 16'(rd_data.h);
    end
    if ((state == S_DIV) && div_rsp.done) begin
      tex[op] <= div_rsp.quot;
    end
    if (emit_load) begin
      out_x      <= ((k == CORNER_TR) || (k == CORNER_BR)) ? x1 : x0;
      out_y      <= ((k == CORNER_BR) || (k == CORNER_BL)) ? y1 : y0;
      out_s      <= ((k == CORNER_TR) || (k == CORNER_BR)) ? tex[1] : tex[0];
      out_t      <= ((k == CORNER_BR) || (k == CORNER_BL)) ? tex[3] : tex[2];
      out_corner <= k;
      out_last   <= (k == CORNER_BL);
    end
  end

  assign verts.valid  = out_valid;
  assign verts.vert_x = out_x;
  assign verts.vert_y = out_y;
  assign verts.tex_s  = out_s;
  assign verts.tex_t  = out_t;
  assign verts.corner = out_corner;
  assign verts.last   = out_last;

`ifndef SYNTHESIS
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("Divider finished outside the division phase.");
  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    $past(state) == S_EMIT && state == S_IDLE |-> out_valid && out_corner == CORNER_BL)
    else $error("Emit phase ended without the final corner in the output register.");
  a_pen_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(accept) && $past(state) != S_READ |-> $stable(pen_x))
    else $error("Pen x changed without a cause.");
`endif

endmodule

// File: src/gql_glyph_mem.sv
// Glyph rectangle memory with one write port and one registered read port.
module gql_glyph_mem import gql_pkg::*; #(
  parameter int DEPTH = 384,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  glyph_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output glyph_t        rd_data
);

  glyph_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/gql_divider.sv
// Iterative saturating divider giving texel / size in Q0.16, four quotient bits a cycle.
module gql_divider import gql_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic                 sat;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TEX_W-1:0]     rem;
  logic [TEX_W-1:0]     quo;
  logic [TEX_W-1:0]     size_q;
  logic [TEX_W-1:0]     rem_next;
  logic [TEX_W-1:0]     quo_next;

  always_comb begin
    logic [TEX_W:0]   t;
    logic [TEX_W-1:0] r;
    logic [TEX_W-1:0] q;
    r = rem;
    q = quo;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, 1'b0};
      if (t >= {1'b0, size_q}) begin
        r = TEX_W'(t - {1'b0, size_q});
        q = {q[TEX_W-2:0], 1'b1};
      end else begin
        r = t[TEX_W-1:0];
        q = {q[TEX_W-2:0], 1'b0};
      end
    end
    rem_next = r;
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sat    <= (req.texel >= {1'b0, req.size});
      rem    <= req.texel[TEX_W-1:0];
      quo    <= '0;
      size_q <= req.size;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = sat ? TEX_MAX : quo;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req.start |-> ##(DIV_CYCLES + 1) rsp.done)
    else $error("Divider result did not arrive on time.");
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("Divider done lasted more than one cycle.");
  a_rem: assert property (@(posedge clk) disable iff (rst)
    busy && !sat && !$past(req.start) |-> rem < size_q)
    else $error("Divider remainder reached the divisor.");
`endif

endmodule

// File: tb/glyph_quad_layout_top_tb.sv
// Self-checking testbench of the glyph quad layout block: directed text, random layout and bursts.
module glyph_quad_layout_top_tb;
  import gql_pkg::*;

  localparam int NUM_FONTS   = 4;
  localparam int GLYPH_COUNT = 96;
  localparam int CLK_PERIOD  = 12;
  localparam int DRAIN_CYCLES = 64;

  localparam logic [1:0] FN_GLYPH   = 2'd0;
  localparam logic [1:0] FN_METRICS = 2'd1;
  localparam logic [1:0] FN_BEGIN   = 2'd2;
  localparam logic [1:0] FN_CHAR    = 2'd3;

  localparam int CH_TAB     = 9;
  localparam int CH_NEWLINE = 10;
  localparam int CH_SPACE   = 32;
  localparam int CH_FIRST   = 32;
  localparam int TAB_MULT   = 4;

  typedef struct {
    logic [1:0]  func;
    logic [1:0]  font_sel;
    logic [6:0]  slot;
    logic [7:0]  char_code;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  size_w;
    logic [7:0]  size_h;
  } text_item_t;

  typedef struct {
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] s;
    logic [15:0] t;
    logic [1:0]  corner;
    logic        last;
  } vert_t;

  logic clk = 1'b0;
  logic rst;

  gql_in_if  item_bus ();
  gql_out_if vert_bus ();

  glyph_quad_layout_top #(
    .NUM_FONTS   (NUM_FONTS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .items (item_bus),
    .verts (vert_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  glyph_t      glyph_mirror [NUM_FONTS][GLYPH_COUNT];
  bit          glyph_known  [NUM_FONTS][GLYPH_COUNT];
  logic [7:0]  line_h [NUM_FONTS];
  logic [15:0] tex_w  [NUM_FONTS];
  logic [15:0] tex_h  [NUM_FONTS];
  logic [15:0] pen_x, pen_y, org_x;

  vert_t       pending_verts [$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  bit          burst_mode = 1'b0;

  function automatic logic [15:0] tex_coord(input logic [16:0] texel, input logic [15:0] size);
    logic [32:0] q;
    if (size == 16'd0) return TEX_MAX;
    q = {texel, 16'd0} / {17'd0, size};
    return (q > 33'h0_FFFF) ? TEX_MAX : q[15:0];
  endfunction

  task automatic push_vert(input logic [15:0] vx, input logic [15:0] vy,
                           input logic [15:0] s, input logic [15:0] t, input logic [1:0] c);
    vert_t v;
    v.vx = vx;
    v.vy = vy;
    v.s = s;
    v.t = t;
    v.corner = c;
    v.last = (c == CORNER_BL);
    pending_verts.push_back(v);
  endtask

  task automatic advance_layout(input text_item_t it);
    glyph_t      g;
    logic [15:0] s0, s1, t0, t1, x1, y1, adv;
    int          f;
    int          code;
    f = it.font_sel;
    code = it.char_code;
    case (it.func)
      FN_GLYPH: begin
        if (it.slot < GLYPH_COUNT) begin
          g.x = it.pos_x;
          g.y = it.pos_y;
          g.w = it.size_w;
          g.h = it.size_h;
          glyph_mirror[f][it.slot] = g;
          glyph_known[f][it.slot] = 1'b1;
        end
      end
      FN_METRICS: begin
        line_h[f] = it.size_h;
        tex_w[f] = it.pos_x;
        tex_h[f] = it.pos_y;
      end
      FN_BEGIN: begin
        org_x = it.pos_x;
        pen_x = it.pos_x;
        pen_y = it.pos_y;
      end
      default: begin
        if (code == CH_NEWLINE) begin
          pen_x = org_x;
          pen_y = pen_y + 16'(line_h[f]);
        end else if (code == CH_TAB || code == CH_SPACE) begin
          adv = 16'(glyph_mirror[f][0].w);
          if (code == CH_TAB) adv = adv * 16'(TAB_MULT);
          pen_x = pen_x + adv;
        end else if (code >= CH_FIRST && code - CH_FIRST < GLYPH_COUNT) begin
          g = glyph_mirror[f][code - CH_FIRST];
          s0 = tex_coord({1'b0, g.x}, tex_w[f]);
          s1 = tex_coord({1'b0, g.x} + 17'(g.w), tex_w[f]);
          t0 = tex_coord({1'b0, g.y}, tex_h[f]);
          t1 = tex_coord({1'b0, g.y} + 17'(g.h), tex_h[f]);
          x1 = pen_x + 16'(g.w);
          y1 = pen_y + 16'(g.h);
          push_vert(pen_x, pen_y, s0, t0, CORNER_TL);
          push_vert(x1, pen_y, s1, t0, CORNER_TR);
          push_vert(x1, y1, s1, t1, CORNER_BR);
          push_vert(pen_x, y1, s0, t1, CORNER_BL);
          pen_x = x1;
        end
      end
    endcase
  endtask

  function automatic text_item_t random_item();
    text_item_t it;
    it.func = 2'($urandom_range(0, 3));
    it.font_sel = 2'($urandom_range(0, NUM_FONTS - 1));
    it.slot = 7'($urandom_range(0, 127));
    it.char_code = 8'($urandom_range(0, 255));
    it.pos_x = 16'($urandom_range(0, 65535));
    it.pos_y = 16'($urandom_range(0, 65535));
    it.size_w = 8'($urandom_range(0, 255));
    it.size_h = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic text_item_t make_glyph(input int f, input int s, input int x, input int y,
                                            input int w, input int h);
    text_item_t it;
    it = random_item();
    it.func = FN_GLYPH;
    it.font_sel = 2'(f);
    it.slot = 7'(s);
    it.pos_x = 16'(x);
    it.pos_y = 16'(y);
    it.size_w = 8'(w);
    it.size_h = 8'(h);
    return it;
  endfunction

  function automatic text_item_t make_metrics(input int f, input int tw, input int th,
                                              input int lh);
    text_item_t it;
    it = random_item();
    it.func = FN_METRICS;
    it.font_sel = 2'(f);
    it.pos_x = 16'(tw);
    it.pos_y = 16'(th);
    it.size_h = 8'(lh);
    return it;
  endfunction

  function automatic text_item_t make_begin(input int f, input int x, input int y);
    text_item_t it;
    it = random_item();
    it.func = FN_BEGIN;
    it.font_sel = 2'(f);
    it.pos_x = 16'(x);
    it.pos_y = 16'(y);
    return it;
  endfunction

  function automatic text_item_t make_char(input int f, input int c);
    text_item_t it;
    it = random_item();
    it.func = FN_CHAR;
    it.font_sel = 2'(f);
    it.char_code = 8'(c);
    return it;
  endfunction

  function automatic int skipped_code();
    int c;
    if ($urandom_range(0, 1) == 0) return $urandom_range(CH_FIRST + GLYPH_COUNT, 255);
    c = $urandom_range(0, CH_FIRST - 3);
    return (c >= CH_TAB) ? c + 2 : c;
  endfunction

  function automatic int random_tex_size();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65535;
      2, 3: return $urandom_range(1, 255);
      4, 5: return $urandom_range(256, 4096);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int random_texel();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2047);
  endfunction

  function automatic int random_slot();
    case ($urandom_range(0, 7))
      0: return $urandom_range(GLYPH_COUNT, 127);
      1, 2: return $urandom_range(0, GLYPH_COUNT - 1);
      default: return $urandom_range(0, 23);
    endcase
  endfunction

  // Only glyphs already written are drawn, so no read of an unwritten entry is caused.
  function automatic int pick_code(input int f);
    int s;
    case ($urandom_range(0, 9))
      0: return CH_NEWLINE;
      1: begin
        if (!glyph_known[f][0]) return CH_NEWLINE;
        return ($urandom_range(0, 1) == 0) ? CH_TAB : CH_SPACE;
      end
      2: return skipped_code();
      default: begin
        repeat (24) begin
          s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, GLYPH_COUNT - 1)
                                          : $urandom_range(0, 23);
          if (glyph_known[f][s] && s != 0) return s + CH_FIRST;
        end
        return CH_NEWLINE;
      end
    endcase
  endfunction

  task automatic send_item(input text_item_t it);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.func      <= it.func;
    item_bus.font_sel  <= it.font_sel;
    item_bus.slot      <= it.slot;
    item_bus.char_code <= it.char_code;
    item_bus.pos_x     <= it.pos_x;
    item_bus.pos_y     <= it.pos_y;
    item_bus.size_w    <= it.size_w;
    item_bus.size_h    <= it.size_h;
    item_bus.valid     <= 1'b1;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    advance_layout(it);
    items_sent++;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : vert_checker
    vert_t v;
    if (!rst && vert_bus.valid && vert_bus.ready) begin
      if (pending_verts.size() == 0) begin
        $error("unexpected vertex transfer: vert_x %0d, vert_y %0d", vert_bus.vert_x,
               vert_bus.vert_y);
        fail_count++;
      end else begin
        v = pending_verts.pop_front();
        check_field("vert_x", v.vx, vert_bus.vert_x);
        check_field("vert_y", v.vy, vert_bus.vert_y);
        check_field("tex_s", v.s, vert_bus.tex_s);
        check_field("tex_t", v.t, vert_bus.tex_t);
        check_field("corner", v.corner, vert_bus.corner);
        check_field("last", v.last, vert_bus.last);
      end
    end
  end

  initial begin : vert_ready_driver
    int unsigned gap;
    vert_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = burst_mode ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        vert_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      vert_bus.ready <= 1'b1;
      @(posedge clk);
      while (!vert_bus.valid) @(posedge clk);
    end
  end

  // Texture sizes are still zero after reset, so every coordinate saturates.
  task automatic test_reset_metrics();
    send_item(make_glyph(0, 33, 0, 0, 8, 12));
    send_item(make_begin(0, 100, 200));
    send_item(make_char(0, 65));
    send_item(make_char(0, CH_NEWLINE));
  endtask

  task automatic test_field_extremes();
    send_item(make_metrics(3, 65535, 65535, 255));
    send_item(make_glyph(3, GLYPH_COUNT - 1, 65535, 65535, 255, 255));
    send_item(make_glyph(3, 1, 0, 0, 0, 0));
    send_item(make_glyph(3, 127, 1, 2, 3, 4));
    send_item(make_begin(3, 65535, 65535));
    send_item(make_char(3, 127));
    send_item(make_char(3, 33));
    send_item(make_metrics(2, 1, 256, 1));
    send_item(make_glyph(2, 94, 0, 128, 1, 128));
    send_item(make_begin(2, 0, 0));
    send_item(make_char(2, 126));
  endtask

  task automatic test_control_chars();
    send_item(make_metrics(1, 512, 512, 16));
    send_item(make_glyph(1, 0, 7, 9, 255, 20));
    send_item(make_glyph(1, 40, 300, 100, 24, 32));
    send_item(make_begin(1, 10, 20));
    send_item(make_char(1, 72));
    send_item(make_char(1, CH_TAB));
    send_item(make_char(1, CH_SPACE));
    send_item(make_char(1, CH_NEWLINE));
    send_item(make_char(1, 0));
    send_item(make_char(1, 31));
    send_item(make_char(1, 128));
    send_item(make_char(1, 255));
    send_item(make_char(1, 72));
  endtask

  task automatic test_random_layout(input int unsigned n_items, input bit all_burst);
    int unsigned stop_at;
    int          f;
    text_item_t  it;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      f = $urandom_range(0, NUM_FONTS - 1);
      burst_mode = all_burst || ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0)
        send_item(make_metrics(f, random_tex_size(), random_tex_size(), $urandom_range(0, 255)));
      repeat ($urandom_range(0, 4))
        send_item(make_glyph(f, random_slot(), random_texel(), random_texel(),
                             $urandom_range(0, 255), $urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0)
        send_item(make_begin(f, $urandom_range(0, 65535), $urandom_range(0, 65535)));
      repeat ($urandom_range(2, 12)) send_item(make_char(f, pick_code(f)));
      if ($urandom_range(0, 5) == 0) begin
        it = random_item();
        if (it.func == FN_CHAR) it.char_code = 8'(skipped_code());
        send_item(it);
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin : main_sequence
    rst <= 1'b1;
    item_bus.valid     <= 1'b0;
    item_bus.func      <= FN_GLYPH;
    item_bus.font_sel  <= 2'd0;
    item_bus.slot      <= 7'd0;
    item_bus.char_code <= 8'd0;
    item_bus.pos_x     <= 16'd0;
    item_bus.pos_y     <= 16'd0;
    item_bus.size_w    <= 8'd0;
    item_bus.size_h    <= 8'd0;
    for (int f = 0; f < NUM_FONTS; f++) begin
      line_h[f] = 8'd0;
      tex_w[f] = 16'd0;
      tex_h[f] = 16'd0;
      for (int s = 0; s < GLYPH_COUNT; s++) glyph_known[f][s] = 1'b0;
    end
    pen_x = 16'd0;
    pen_y = 16'd0;
    org_x = 16'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_metrics();
    test_field_extremes();
    test_control_chars();
    test_random_layout(340, 1'b0);
    test_random_layout(40, 1'b1);

    item_bus.valid <= 1'b0;
    while (pending_verts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * 400000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
